>>> rtl/core/tone_sequence_player_unit_macros.svh
// Assertion helpers for the tone sequence player checkers.
`ifndef TONE_SEQUENCE_PLAYER_UNIT_MACROS_SVH
`define TONE_SEQUENCE_PLAYER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tsp_pkg.sv
package tsp_pkg;

  // Cap on notes played from one sound.
  localparam int MAX_SEQ_NOTES = 4;

  localparam int FREQ_W = 12;
  localparam int DUR_W  = 8;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_PLAY = 2'd1,
    FUNC_STOP = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    SND_CLICK   = 3'd0,
    SND_MENU    = 3'd1,
    SND_ERROR   = 3'd2,
    SND_SUCCESS = 3'd3,
    SND_BOOT    = 3'd4
  } sound_t;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] sound_id;
    logic       mic_owns;
  } tsp_item_t;

  typedef struct packed {
    logic              tone_start;
    logic [FREQ_W-1:0] tone_freq;
    logic [DUR_W-1:0]  tone_dur;
    logic              speaker_stop;
    logic              busy_res;
  } tsp_res_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } note_t;

  // Notes per sound, capped; zero for ids outside the ROM.
  function automatic logic [2:0] seq_len(input logic [2:0] sid);
    logic [2:0] n;
    case (sid)
      SND_CLICK:   n = 3'd1;
      SND_MENU:    n = 3'd2;
      SND_ERROR:   n = 3'd2;
      SND_SUCCESS: n = 3'd2;
      SND_BOOT:    n = 3'd4;
      default:     n = 3'd0;
    endcase
    if (int'(n) > MAX_SEQ_NOTES) n = 3'(MAX_SEQ_NOTES);
    return n;
  endfunction

  // Sound ROM: frequency in Hz and duration in ms.
  function automatic note_t note_rom(input logic [2:0] sid, input logic [1:0] idx);
    note_t n;
    n = '0;
    case (sid)
      SND_CLICK: begin
        case (idx)
          2'd0:    n = '{12'd1800, 8'd22};
          default: n = '0;
        endcase
      end
      SND_MENU: begin
        case (idx)
          2'd0:    n = '{12'd900, 8'd26};
          2'd1:    n = '{12'd1350, 8'd34};
          default: n = '0;
        endcase
      end
      SND_ERROR: begin
        case (idx)
          2'd0:    n = '{12'd420, 8'd80};
          2'd1:    n = '{12'd280, 8'd130};
          default: n = '0;
        endcase
      end
      SND_SUCCESS: begin
        case (idx)
          2'd0:    n = '{12'd1100, 8'd45};
          2'd1:    n = '{12'd1450, 8'd60};
          default: n = '0;
        endcase
      end
      SND_BOOT: begin
        case (idx)
          2'd0:    n = '{12'd620, 8'd60};
          2'd1:    n = '{12'd880, 8'd60};
          2'd2:    n = '{12'd1240, 8'd90};
          default: n = '{12'd1480, 8'd120};
        endcase
      end
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/tsp_in_if.sv
interface tsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] sound_id;
  logic       mic_owns;

  modport source (output valid, func, sound_id, mic_owns, input ready);
  modport sink   (input valid, func, sound_id, mic_owns, output ready);
endinterface

>>> rtl/core/tsp_out_if.sv
interface tsp_out_if;
  logic        valid;
  logic        ready;
  logic        tone_start;
  logic [11:0] tone_freq;
  logic [7:0]  tone_dur;
  logic        speaker_stop;
  logic        busy_res;

  modport source (output valid, tone_start, tone_freq, tone_dur, speaker_stop, busy_res,
                  input ready);
  modport sink   (input valid, tone_start, tone_freq, tone_dur, speaker_stop, busy_res,
                  output ready);
endinterface

>>> rtl/core/tsp_in_stage.sv
module tsp_in_stage
  import tsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tsp_in_if.sink    in_if,
  input  logic      take,
  output tsp_item_t item,
  output logic      item_valid
);

  logic      valid_r, valid_nxt;
  tsp_item_t item_r;
  logic      load;

  // Holding register frees up when its beat moves on this cycle.
  assign in_if.ready = !valid_r || take;
  assign load        = in_if.valid && in_if.ready;
  assign valid_nxt   = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{in_if.func, in_if.sound_id, in_if.mic_owns};
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

>>> rtl/core/tsp_seq_engine.sv
module tsp_seq_engine
  import tsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tsp_item_t item,
  input  logic      advance,
  output tsp_res_t  res
);

  logic             playing_r, playing_nxt;
  logic [2:0]       seq_r, seq_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [DUR_W-1:0] ms_r, ms_nxt;

  logic [2:0] len_cur;
  logic [2:0] len_new;
  logic [2:0] next_idx;
  note_t      note_next;
  note_t      note_first;

  assign len_cur    = seq_len(seq_r);
  assign len_new    = seq_len(item.sound_id);
  assign next_idx   = {1'b0, idx_r} + 3'd1;
  assign note_next  = note_rom(seq_r, next_idx[1:0]);
  assign note_first = note_rom(item.sound_id, 2'd0);

  always_comb begin
    playing_nxt = playing_r;
    seq_nxt     = seq_r;
    idx_nxt     = idx_r;
    ms_nxt      = ms_r;
    res         = '0;

    case (item.func)
      FUNC_TICK: begin
        if (item.mic_owns) begin
          // mic grabbed the codec: kill an active sound
          if (playing_r) begin
            playing_nxt      = 1'b0;
            seq_nxt          = '0;
            idx_nxt          = '0;
            ms_nxt           = '0;
            res.speaker_stop = 1'b1;
          end
        end else if (playing_r) begin
          if (ms_r > 8'd1) begin
            ms_nxt = ms_r - 8'd1;
          end else if (next_idx >= len_cur) begin
            // last note done; go quiet without a stop command
            playing_nxt = 1'b0;
            seq_nxt     = '0;
            idx_nxt     = '0;
            ms_nxt      = '0;
          end else begin
            idx_nxt        = next_idx[1:0];
            ms_nxt         = note_next.dur;
            res.tone_start = 1'b1;
            res.tone_freq  = note_next.freq;
            res.tone_dur   = note_next.dur;
          end
        end
      end
      FUNC_PLAY: begin
        if (!item.mic_owns && (len_new != 3'd0)) begin
          playing_nxt    = 1'b1;
          seq_nxt        = item.sound_id;
          idx_nxt        = '0;
          ms_nxt         = note_first.dur;
          res.tone_start = 1'b1;
          res.tone_freq  = note_first.freq;
          res.tone_dur   = note_first.dur;
        end
      end
      FUNC_STOP: begin
        playing_nxt      = 1'b0;
        seq_nxt          = '0;
        idx_nxt          = '0;
        ms_nxt           = '0;
        res.speaker_stop = 1'b1;
      end
      default: begin
      end
    endcase

    res.busy_res = playing_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      seq_r     <= '0;
      idx_r     <= '0;
      ms_r      <= '0;
    end else if (advance) begin
      playing_r <= playing_nxt;
      seq_r     <= seq_nxt;
      idx_r     <= idx_nxt;
      ms_r      <= ms_nxt;
    end
  end

endmodule

>>> rtl/core/tsp_out_stage.sv
module tsp_out_stage
  import tsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  tsp_res_t res,
  input  logic     load,
  output logic     space,
  tsp_out_if.source out_if
);

  logic     valid_r, valid_nxt;
  tsp_res_t res_r;

  // Room for a new beat when empty or the held one leaves now.
  assign space     = !valid_r || out_if.ready;
  assign valid_nxt = load || (valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_if.valid        = valid_r;
  assign out_if.tone_start   = res_r.tone_start;
  assign out_if.tone_freq    = res_r.tone_freq;
  assign out_if.tone_dur     = res_r.tone_dur;
  assign out_if.speaker_stop = res_r.speaker_stop;
  assign out_if.busy_res     = res_r.busy_res;

endmodule

>>> rtl/core/tone_sequence_player_unit.sv
// An accepted input beat passes the input register, then the result register, to out_if.
// Throughput: one item per cycle unless out_if stalls; state updates in one pass.
// Rate set by the combinational state update between input and result registers.
// Reset (rst_n low, synchronous): idle, no sound selected, both registers empty.
module tone_sequence_player_unit
  import tsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tsp_in_if.sink    in_if,
  tsp_out_if.source out_if
);

  // Pipeline:
  //   in_if -> input register -> sequencer step (state + ROM lookup) -> result register
  // A beat leaves the input register only when the result register has room,
  // which is either empty or being drained this cycle, so both sides stream.

  tsp_item_t item;
  logic      item_valid;
  logic      out_space;
  logic      advance;
  tsp_res_t  res;

  // One step per beat; state only moves when the result is captured.
  assign advance = item_valid && out_space;

  tsp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .take       (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  // Sequencer: playing flag, sound, note index and ms countdown, plus the
  // note ROM. Ticks count down; at the end of a note the next tone, if any, is issued.
  tsp_seq_engine u_eng (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .res     (res)
  );

  tsp_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .load   (advance),
    .space  (out_space),
    .out_if (out_if)
  );

endmodule

>>> rtl/core/tsp_chk.sv
`include "tone_sequence_player_unit_macros.svh"

module tsp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        tone_start,
  input logic [11:0] tone_freq,
  input logic [7:0]  tone_dur,
  input logic        speaker_stop,
  input logic        busy_res
);

  // A tone and a stop never share a beat.
  `TSP_ASSERT_NOW(a_tone_xor_stop, clk, rst_n, out_valid, !(tone_start && speaker_stop), "tone and stop in one beat")

  // No tone command means empty tone fields.
  `TSP_ASSERT_NOW(a_idle_fields, clk, rst_n, out_valid && !tone_start, (tone_freq == 12'd0) && (tone_dur == 8'd0), "tone fields set without tone")

  // Issuing a tone leaves a sound playing; a stop leaves none.
  `TSP_ASSERT_NOW(a_tone_busy, clk, rst_n, out_valid && tone_start, busy_res && (tone_dur != 8'd0), "tone without busy")
  `TSP_ASSERT_NOW(a_stop_idle, clk, rst_n, out_valid && speaker_stop, !busy_res, "busy after stop")

  // Stalled result beat holds.
  `TSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(tone_start) && $stable(tone_freq) && $stable(tone_dur) && $stable(speaker_stop) && $stable(busy_res), "stalled beat changed")

endmodule

bind tone_sequence_player_unit tsp_chk u_tsp_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .tone_start   (out_if.tone_start),
  .tone_freq    (out_if.tone_freq),
  .tone_dur     (out_if.tone_dur),
  .speaker_stop (out_if.speaker_stop),
  .busy_res     (out_if.busy_res)
);

>>> tb/tone_sequence_player_unit_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts each result beat and compares it field by field.
module tone_sequence_player_unit_checker
  import tsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tsp_in_if    in_mon,
  tsp_out_if   out_mon,
  output int   fail_count,
  output int   results_owed
);

  localparam int NUM_SOUNDS = 5;
  localparam int ROM_DEPTH  = 4;

  localparam int ROM_LEN [NUM_SOUNDS] = '{1, 2, 2, 2, 4};

  localparam logic [FREQ_W-1:0] ROM_HZ [NUM_SOUNDS][ROM_DEPTH] = '{
    '{12'd1800, 12'd0,    12'd0,    12'd0},
    '{12'd900,  12'd1350, 12'd0,    12'd0},
    '{12'd420,  12'd280,  12'd0,    12'd0},
    '{12'd1100, 12'd1450, 12'd0,    12'd0},
    '{12'd620,  12'd880,  12'd1240, 12'd1480}
  };

  localparam logic [DUR_W-1:0] ROM_MS [NUM_SOUNDS][ROM_DEPTH] = '{
    '{8'd22, 8'd0,   8'd0,  8'd0},
    '{8'd26, 8'd34,  8'd0,  8'd0},
    '{8'd80, 8'd130, 8'd0,  8'd0},
    '{8'd45, 8'd60,  8'd0,  8'd0},
    '{8'd60, 8'd60,  8'd90, 8'd120}
  };

  // Predicted sequencer state
  logic             snd_active;
  logic [2:0]       snd_sel;
  logic [1:0]       note_pos;
  logic [DUR_W-1:0] ms_remaining;

  tsp_res_t tone_cmd_q[$];

  // Notes played from a sound; zero for ids past the ROM.
  function automatic int notes_in(input logic [2:0] sid);
    if (int'(sid) >= NUM_SOUNDS) return 0;
    return (ROM_LEN[sid] > MAX_SEQ_NOTES) ? MAX_SEQ_NOTES : ROM_LEN[sid];
  endfunction

  task automatic silence;
    snd_active   = 1'b0;
    snd_sel      = '0;
    note_pos     = '0;
    ms_remaining = '0;
  endtask

  task automatic sound_note(input int idx, inout tsp_res_t res);
    note_pos        = 2'(idx);
    ms_remaining    = ROM_MS[snd_sel][idx];
    res.tone_start  = 1'b1;
    res.tone_freq   = ROM_HZ[snd_sel][idx];
    res.tone_dur    = ROM_MS[snd_sel][idx];
  endtask

  task automatic player_step(input tsp_item_t item, output tsp_res_t res);
    res = '0;
    case (item.func)
      FUNC_TICK: begin
        if (snd_active) begin
          if (item.mic_owns) begin
            // mic grabs the codec mid-sound
            silence();
            res.speaker_stop = 1'b1;
          end else if (ms_remaining > 1) begin
            ms_remaining = ms_remaining - 1'b1;
          end else if (int'(note_pos) + 1 >= notes_in(snd_sel)) begin
            silence();
          end else begin
            sound_note(int'(note_pos) + 1, res);
          end
        end
      end
      FUNC_PLAY: begin
        if (!item.mic_owns && notes_in(item.sound_id) > 0) begin
          snd_sel    = item.sound_id;
          snd_active = 1'b1;
          sound_note(0, res);
        end
      end
      FUNC_STOP: begin
        silence();
        res.speaker_stop = 1'b1;
      end
      default: ;
    endcase
    res.busy_res = snd_active;
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tsp_item_t item;
    tsp_res_t  want;
    tsp_res_t  got;
    if (!rst_n) begin
      silence();
      tone_cmd_q.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        item.func     = in_mon.func;
        item.sound_id = in_mon.sound_id;
        item.mic_owns = in_mon.mic_owns;
        player_step(item, want);
        tone_cmd_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.tone_start   = out_mon.tone_start;
        got.tone_freq    = out_mon.tone_freq;
        got.tone_dur     = out_mon.tone_dur;
        got.speaker_stop = out_mon.speaker_stop;
        got.busy_res     = out_mon.busy_res;
        if (tone_cmd_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat expected none actual %h", $time, got);
        end else begin
          want = tone_cmd_q.pop_front();
          check_field("tone_start", want.tone_start, got.tone_start);
          check_field("tone_freq", want.tone_freq, got.tone_freq);
          check_field("tone_dur", want.tone_dur, got.tone_dur);
          check_field("speaker_stop", want.speaker_stop, got.speaker_stop);
          check_field("busy_res", want.busy_res, got.busy_res);
        end
      end
    end
    results_owed <= tone_cmd_q.size();
  end

endmodule

>>> tb/tone_sequence_player_unit_test.sv
`timescale 1ns / 100ps

// Top of the bench: clock, reset, stimulus on the input channel, random back
// pressure on the result channel, and the verdict. All checking lives in the
// checker instance.
module tone_sequence_player_unit_test;
  import tsp_pkg::*;

  localparam int CLK_HALF     = 10;      // 20 ns period
  localparam int RESET_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int HOLD_BEATS   = 40;      // beats offered while held off
  localparam int DRAIN_CYCLES = 8;       // idle cycles after the final drain
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 400;

  // func 3 has no meaning; the block must just report busy
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Full length in ms of each sound, used to size tick runs
  localparam int SOUND_MS [5] = '{22, 60, 210, 105, 330};

  logic clk;
  logic rst_n;

  tsp_in_if  in_if();
  tsp_out_if out_if();

  int fail_count;
  int results_owed;

  // Idle/stall odds in percent per cycle, set per phase
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_asked;
  int hold_done;
  int items_sent;
  int phase_end;
  int cycle_count;

  tone_sequence_player_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  tone_sequence_player_unit_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tone_sequence_player_unit: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls per phase, plus a long hold-off when asked for.
  // The hold is counted here so the sender keeps pushing beats meanwhile.
  initial begin : receiver
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        hold_done++;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one beat, with random sender gaps in front of it. valid stays high
  // across back-to-back beats; it only drops when a gap is inserted.
  task automatic send_beat(input logic [1:0] func, input logic [2:0] sid,
                           input logic mic);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.func     <= func;
    in_if.sound_id <= sid;
    in_if.mic_owns <= mic;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Any encoding at all, including func 3 and unknown sounds
  task automatic random_beat;
    send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)));
  endtask

  // Sender stops and waits until every predicted result has come back.
  // results_owed is updated at the edge, so look after the next edge.
  task automatic wait_drained;
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic random_scenario;
    int pick;
    int ticks;
    int upset_pct;
    int r;
    logic [2:0] sid;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // Well-formed: start a sound and tick it out, usually to the end.
      // Some runs get cut short, some get disturbed by mic, stop or junk.
      sid = 3'($urandom_range(0, 4));
      send_beat(FUNC_PLAY, sid, 1'b0);
      ticks = SOUND_MS[sid] + $urandom_range(0, 3);
      if ($urandom_range(3) == 0) ticks = $urandom_range(1, ticks);
      upset_pct = ($urandom_range(99) < 40) ? 3 : 0;
      for (int k = 0; k < ticks && items_sent < phase_end; k++) begin
        r = $urandom_range(99);
        if (r < upset_pct) begin
          case ($urandom_range(2))
            0:       send_beat(FUNC_TICK, 3'($urandom_range(0, 7)), 1'b1);
            1:       send_beat(FUNC_STOP, 3'($urandom_range(0, 7)),
                               1'($urandom_range(0, 1)));
            default: random_beat();
          endcase
        end else begin
          send_beat(FUNC_TICK, 3'($urandom_range(0, 7)), 1'b0);
        end
      end
    end else if (pick < 90) begin
      // noise burst
      repeat ($urandom_range(1, 8)) random_beat();
    end else begin
      // ticks, often with nothing playing, mic either way
      repeat ($urandom_range(1, 10))
        send_beat(FUNC_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    phase_end    = items_sent + PHASE_ITEMS;
    while (items_sent < phase_end) random_scenario();
  endtask

  initial begin : stimulus
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.func     <= FUNC_TICK;
    in_if.sound_id <= SND_CLICK;
    in_if.mic_owns <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_asked   = 0;
    items_sent   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle corners first
    send_beat(FUNC_TICK, SND_CLICK, 1'b0);
    send_beat(FUNC_TICK, 3'd7, 1'b1);          // mic tick while idle: no stop
    send_beat(FUNC_STOP, SND_CLICK, 1'b0);     // stop while idle still reports
    send_beat(FUNC_SPARE, 3'd7, 1'b1);
    // unknown sounds are dropped
    send_beat(FUNC_PLAY, 3'd5, 1'b0);
    send_beat(FUNC_PLAY, 3'd6, 1'b0);
    send_beat(FUNC_PLAY, 3'd7, 1'b0);
    send_beat(FUNC_PLAY, SND_CLICK, 1'b1);     // mic owns: play ignored
    // every sound, each one restarting the previous
    send_beat(FUNC_PLAY, SND_CLICK, 1'b0);
    send_beat(FUNC_PLAY, SND_MENU, 1'b0);
    send_beat(FUNC_PLAY, SND_ERROR, 1'b0);
    send_beat(FUNC_PLAY, SND_SUCCESS, 1'b0);
    send_beat(FUNC_PLAY, SND_BOOT, 1'b0);
    send_beat(FUNC_TICK, SND_CLICK, 1'b0);
    send_beat(FUNC_SPARE, 3'd7, 1'b1);         // spare func while playing
    send_beat(FUNC_TICK, SND_CLICK, 1'b1);     // mic takes over: speaker stop
    send_beat(FUNC_PLAY, SND_BOOT, 1'b0);
    send_beat(FUNC_STOP, SND_BOOT, 1'b1);      // stop wins whatever the mic
    send_beat(FUNC_PLAY, SND_CLICK, 1'b0);
    send_beat(FUNC_SPARE, SND_CLICK, 1'b0);
    wait_drained();

    // Receiver held off for a long stretch while beats keep coming, so the
    // block backs up and stalls its input.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_asked++;
    phase_end = items_sent + HOLD_BEATS;
    send_beat(FUNC_PLAY, SND_SUCCESS, 1'b0);
    while (items_sent < phase_end) random_beat();
    wait_drained();

    run_phase(0, 0);
    wait_drained();
    run_phase(52, 0);
    wait_drained();
    run_phase(0, 52);
    run_phase(20, 20);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tone_sequence_player_unit: match");
    end else begin
      $display("tone_sequence_player_unit: mismatch");
    end
    $finish;
  end

endmodule
